### hw/rtl/bts_pkg.sv
// shared constants and types for the bilinear texture sampler
`default_nettype none

package bts_pkg;

	localparam int DIM_W      = 7;
	localparam int ADDR_W     = 12;
	localparam int STORE_DEPTH = 4096;
	localparam int TEXEL_W    = 32;
	localparam int COORD_W    = 18;
	localparam int UC_W       = 17;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 4;
	localparam int NUM_TAPS   = 4;

	localparam logic [UC_W-1:0] COORD_ONE = 17'h10000;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic REG_TEX_WIDTH  = 1'b0;
	localparam logic REG_TEX_HEIGHT = 1'b1;

	// tap order of the four neighbors
	localparam int TAP_00 = 0;
	localparam int TAP_10 = 1;
	localparam int TAP_01 = 2;
	localparam int TAP_11 = 3;

	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [TEXEL_W-1:0] texel_t;
	typedef logic [UC_W-1:0]    ucoord_t;

endpackage

`default_nettype wire

### hw/rtl/bts_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module bts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/bilinear_texture_sampler_core.sv
// bilinear texture sampler top level: pipeline, texel store copies, output register
// results leave via the output register; the pipeline stalls while it is held
// throughput when not stalled: one item (write or sample) per cycle; four copies of
//   the texel store each give one neighbor per cycle, writes go to all copies
//   in the same stage; reset clears handshake state and the size registers;
//   store contents stay undefined until written, no clearing pass
`default_nettype none

module bilinear_texture_sampler_core
	import bts_pkg::*;
#(
	parameter int MAX_DIM   = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire [6:0]   cfg_data,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [79:0]  s_axis_tdata,   // texel_index, texel_rgba, u_coord, v_coord
	input  wire [0:0]   s_axis_tuser,   // cmd
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata    // red, green, blue, alpha
);

	localparam int WT_W  = FRAC_BITS + 1;
	localparam int TB_W  = FRAC_BITS + CHAN_W;
	localparam int ACC_W = 2 * FRAC_BITS + CHAN_W + 2;
	localparam int FX_W  = UC_W + DIM_W;
	localparam int RA_W  = 2 * DIM_W;
	localparam int WSHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int WSHR  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [WT_W-1:0] W_ONE = WT_W'(1) << FRAC_BITS;

	typedef logic [WT_W-1:0] weight_t;

	function automatic ucoord_t clamp_coord(input logic [COORD_W-1:0] c);
		ucoord_t r;
		if (c[COORD_W-1]) begin
			r = '0;
		end else if (c[UC_W-1:0] > COORD_ONE) begin
			r = COORD_ONE;
		end else begin
			r = c[UC_W-1:0];
		end
		return r;
	endfunction

	function automatic weight_t to_weight(input logic [15:0] f);
		logic [WT_W+15:0] t;
		t = (WT_W+16)'(f);
		t = (t << WSHL) >> WSHR;
		return t[WT_W-1:0];
	endfunction

	function automatic dim_t clamp_dim(input dim_t d);
		dim_t r;
		if (int'(d) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

	// configuration registers
	dim_t tex_width_q, tex_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= '0;
			tex_height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEX_WIDTH:  tex_width_q  <= cfg_data;
				REG_TEX_HEIGHT: tex_height_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	dim_t w_eff, h_eff, w_m1, h_m1;
	logic empty;

	always_comb begin
		w_eff = clamp_dim(tex_width_q);
		h_eff = clamp_dim(tex_height_q);
		w_m1  = w_eff - DIM_W'(1);
		h_m1  = h_eff - DIM_W'(1);
		empty = (tex_width_q == '0) || (tex_height_q == '0);
	end

	// the whole pipeline moves when the output register is free or being taken
	logic adv;
	logic out_vld_q;

	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: capture and clamp coordinates
	logic    v_s1, cmd_s1;
	addr_t   idx_s1;
	texel_t  rgba_s1;
	ucoord_t uc_s1, vc_s1;

	// stage 2: integer positions and weights
	logic    v_s2, cmd_s2;
	addr_t   idx_s2;
	texel_t  rgba_s2;
	dim_t    x0_s2, x1_s2, y0_s2, y1_s2;
	weight_t tx_s2, ty_s2;

	// stage 3: store access
	logic    v_s3, cmd_s3;
	addr_t   idx_s3;
	texel_t  rgba_s3;
	dim_t    x0_s3, x1_s3, y0_s3, y1_s3;
	weight_t tx_s3, ty_s3;

	// stage 4: texels back from the store
	logic    v_s4;
	weight_t tx_s4, ty_s4;

	// stage 5: horizontal blends
	logic    v_s5;
	weight_t ty_s5;
	logic [TB_W-1:0] top_s5 [NUM_CHAN];
	logic [TB_W-1:0] bot_s5 [NUM_CHAN];

	logic [31:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= s_axis_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3 && (cmd_s3 == CMD_SAMPLE);
			v_s5      <= v_s4;
			out_vld_q <= v_s5;
		end
	end

	// stage 2 logic
	logic [FX_W-1:0] fx, fy;
	dim_t x0_c, y0_c;
	logic [DIM_W:0] x0p, y0p;

	always_comb begin
		fx   = FX_W'(uc_s1) * FX_W'(w_m1);
		fy   = FX_W'(vc_s1) * FX_W'(h_m1);
		x0_c = fx[16 +: DIM_W];
		y0_c = fy[16 +: DIM_W];
		x0p  = {1'b0, x0_c} + (DIM_W+1)'(1);
		y0p  = {1'b0, y0_c} + (DIM_W+1)'(1);
	end

	// stage 3 logic: neighbor addresses
	logic [RA_W-1:0] row0, row1;
	addr_t raddr [NUM_TAPS];
	texel_t rdata [NUM_TAPS];
	logic ram_we, ram_re;

	always_comb begin
		row0 = RA_W'(y0_s3) * RA_W'(w_eff);
		row1 = RA_W'(y1_s3) * RA_W'(w_eff);
		raddr[TAP_00] = ADDR_W'(row0 + RA_W'(x0_s3));
		raddr[TAP_10] = ADDR_W'(row0 + RA_W'(x1_s3));
		raddr[TAP_01] = ADDR_W'(row1 + RA_W'(x0_s3));
		raddr[TAP_11] = ADDR_W'(row1 + RA_W'(x1_s3));
		ram_we = adv && v_s3 && (cmd_s3 == CMD_WRITE);
		ram_re = adv && v_s3 && (cmd_s3 == CMD_SAMPLE);
	end

	// writes land in the same stage that reads issue, so order is kept
	for (genvar k = 0; k < NUM_TAPS; k++) begin : g_store
		bts_ram #(
			.WIDTH(TEXEL_W),
			.DEPTH(STORE_DEPTH)
		) u_store (
			.clk  (clk),
			.we   (ram_we),
			.waddr(idx_s3),
			.wdata(rgba_s3),
			.re   (ram_re),
			.raddr(raddr[k]),
			.rdata(rdata[k])
		);
	end

	// stage 4 logic: horizontal blend per channel
	logic [TB_W-1:0] top_c [NUM_CHAN];
	logic [TB_W-1:0] bot_c [NUM_CHAN];
	weight_t tx_inv;

	always_comb begin
		tx_inv = W_ONE - tx_s4;
		for (int c = 0; c < NUM_CHAN; c++) begin
			top_c[c] = TB_W'(rdata[TAP_00][c*CHAN_W +: CHAN_W]) * TB_W'(tx_inv)
				+ TB_W'(rdata[TAP_10][c*CHAN_W +: CHAN_W]) * TB_W'(tx_s4);
			bot_c[c] = TB_W'(rdata[TAP_01][c*CHAN_W +: CHAN_W]) * TB_W'(tx_inv)
				+ TB_W'(rdata[TAP_11][c*CHAN_W +: CHAN_W]) * TB_W'(tx_s4);
		end
	end

	// stage 5 logic: vertical blend and truncation
	logic [ACC_W-1:0] acc [NUM_CHAN];
	logic [31:0] blend;
	weight_t ty_inv;

	always_comb begin
		ty_inv = W_ONE - ty_s5;
		blend  = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			acc[c] = ACC_W'(top_s5[c]) * ACC_W'(ty_inv) + ACC_W'(bot_s5[c]) * ACC_W'(ty_s5);
			blend[c*CHAN_W +: CHAN_W] = acc[c][2*FRAC_BITS +: CHAN_W];
		end
		// empty texture reads as opaque black
		if (empty) begin
			blend = {8'hFF, 24'h000000};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= s_axis_tuser[0];
			idx_s1  <= s_axis_tdata[11:0];
			rgba_s1 <= s_axis_tdata[43:12];
			uc_s1   <= clamp_coord(s_axis_tdata[61:44]);
			vc_s1   <= clamp_coord(s_axis_tdata[79:62]);

			cmd_s2  <= cmd_s1;
			idx_s2  <= idx_s1;
			rgba_s2 <= rgba_s1;
			x0_s2   <= x0_c;
			y0_s2   <= y0_c;
			x1_s2   <= (x0p < {1'b0, w_eff}) ? x0p[DIM_W-1:0] : w_m1;
			y1_s2   <= (y0p < {1'b0, h_eff}) ? y0p[DIM_W-1:0] : h_m1;
			tx_s2   <= to_weight(fx[15:0]);
			ty_s2   <= to_weight(fy[15:0]);

			cmd_s3  <= cmd_s2;
			idx_s3  <= idx_s2;
			rgba_s3 <= rgba_s2;
			x0_s3   <= x0_s2;
			x1_s3   <= x1_s2;
			y0_s3   <= y0_s2;
			y1_s3   <= y1_s2;
			tx_s3   <= tx_s2;
			ty_s3   <= ty_s2;

			tx_s4   <= tx_s3;
			ty_s4   <= ty_s3;

			ty_s5   <= ty_s4;
			for (int c = 0; c < NUM_CHAN; c++) begin
				top_s5[c] <= top_c[c];
				bot_s5[c] <= bot_c[c];
			end

			out_data_q <= blend;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
